@@ src/assert_macros.svh @@
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

@@ src/ebml_pkg.sv @@
`timescale 1ns / 1ps

package ebml_pkg;

   localparam int MAX_ID_BYTES   = 4;
   localparam int MAX_SIZE_BYTES = 8;

   localparam logic [7:0] SIZE_UNKNOWN_CODE = 8'hFF;

   // Result status codes
   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_ID_LEAD   = 2'd1,
      ERR_SIZE_LEAD = 2'd2,
      ERR_TRUNC     = 2'd3
   } error_code_type;

   // Which field the next byte belongs to
   typedef enum logic {
      PHASE_ID   = 1'b0,
      PHASE_SIZE = 1'b1
   } phase_type;

   // ID length from the leading marker among the top four bits, 0 if none
   function automatic logic [2:0] id_len_of(input logic [7:0] b);
      logic [2:0] len;
      len = 3'd0;
      if ((b & 8'h80) != 8'h00) begin
         len = 3'd1;
      end else if ((b & 8'h40) != 8'h00) begin
         len = 3'd2;
      end else if ((b & 8'h20) != 8'h00) begin
         len = 3'd3;
      end else if ((b & 8'h10) != 8'h00) begin
         len = 3'd4;
      end
      return len;
   endfunction

   // Size length from the leading set bit, 0 for a zero byte
   function automatic logic [3:0] size_len_of(input logic [7:0] b);
      logic [3:0] len;
      len = 4'd0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            len = 4'(8 - i);
         end
      end
      return len;
   endfunction

endpackage

@@ src/ebml_element_header_parser_unit.sv @@
`timescale 1ns / 1ps
// EBML element header parser.
// Input channel (req_*): one stream byte per word, with req_end_of_data set on
// the last byte of a buffer. Result channel (rsp_*): one word per finished or
// failed header: packed ID with marker bits, ID length, size with its marker
// removed (or the unknown code 0xFF with rsp_size_unknown), size length and an
// error code (bad ID lead, zero size lead, truncated). Errors clear all other
// fields and parsing restarts at an ID with the next byte.
// Throughput: one byte per cycle. Each byte is decoded by the parse state
// registers in the cycle it is accepted; the edge that accepts a header's final
// byte loads the output register, so rsp_valid rises in the following cycle.
// The output register holds one result. While that result waits untaken, every
// input byte is held off (req_ready = !rsp_valid || rsp_ready), so a stalled
// receiver stops the byte stream with at most one result pending.
// Reset (synchronous, active high) returns the parser to expecting an ID and
// drops any pending result.

module ebml_element_header_parser_unit
   import ebml_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_element_id,
   output logic [2:0]  rsp_id_length,
   output logic [55:0] rsp_element_size,
   output logic [3:0]  rsp_size_length,
   output logic        rsp_size_unknown,
   output logic [1:0]  rsp_error_code
);

`include "assert_macros.svh"

   // Parse state
   phase_type      phase_ff, phase_in;
   logic [3:0]     remain_ff, remain_in;
   logic [31:0]    id_acc_ff, id_acc_in;
   logic [2:0]     id_cnt_ff, id_cnt_in;
   logic [55:0]    size_acc_ff, size_acc_in;
   logic [3:0]     size_cnt_ff, size_cnt_in;

   // Result register
   logic           rsp_valid_ff, rsp_valid_in;
   logic [31:0]    rsp_id_ff, rsp_id_in;
   logic [2:0]     rsp_id_len_ff, rsp_id_len_in;
   logic [55:0]    rsp_size_ff, rsp_size_in;
   logic [3:0]     rsp_size_len_ff, rsp_size_len_in;
   logic           rsp_unknown_ff, rsp_unknown_in;
   error_code_type rsp_err_ff, rsp_err_in;

   logic           accept;
   logic           emit;
   logic           clear;
   logic [2:0]     id_len;
   logic [3:0]     size_len;
   logic [3:0]     rem_next;
   logic [7:0]     lead_mask;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign id_len    = id_len_of(req_data_byte);
   assign size_len  = size_len_of(req_data_byte);
   assign lead_mask = 8'h80 >> (size_len - 4'd1);

   // Per-byte decode and result formation
   always_comb begin
      phase_in        = phase_ff;
      remain_in       = remain_ff;
      id_acc_in       = id_acc_ff;
      id_cnt_in       = id_cnt_ff;
      size_acc_in     = size_acc_ff;
      size_cnt_in     = size_cnt_ff;
      emit            = 1'b0;
      clear           = 1'b0;
      rem_next        = remain_ff;
      rsp_id_in       = '0;
      rsp_id_len_in   = '0;
      rsp_size_in     = '0;
      rsp_size_len_in = '0;
      rsp_unknown_in  = 1'b0;
      rsp_err_in      = ERR_NONE;

      if (accept) begin
         case (phase_ff)
            PHASE_ID: begin
               if (remain_ff == 4'd0 &&
                   (id_len == 3'd0 || int'(id_len) > MAX_ID_BYTES)) begin
                  emit       = 1'b1;
                  clear      = 1'b1;
                  rsp_err_in = ERR_ID_LEAD;
               end else begin
                  if (remain_ff == 4'd0) begin
                     id_acc_in = {24'd0, req_data_byte};
                     id_cnt_in = 3'd1;
                     rem_next  = {1'b0, id_len} - 4'd1;
                  end else begin
                     id_acc_in = {id_acc_ff[23:0], req_data_byte};
                     id_cnt_in = id_cnt_ff + 3'd1;
                     rem_next  = remain_ff - 4'd1;
                  end
                  remain_in = rem_next;
                  if (rem_next == 4'd0) begin
                     phase_in = PHASE_SIZE;
                  end
                  // the size is still due, so a buffer end here truncates
                  if (req_end_of_data) begin
                     emit       = 1'b1;
                     clear      = 1'b1;
                     rsp_err_in = ERR_TRUNC;
                  end
               end
            end
            PHASE_SIZE: begin
               if (remain_ff == 4'd0 &&
                   (size_len == 4'd0 || int'(size_len) > MAX_SIZE_BYTES)) begin
                  emit       = 1'b1;
                  clear      = 1'b1;
                  rsp_err_in = ERR_SIZE_LEAD;
               end else if (remain_ff == 4'd0 && size_len == 4'd1 &&
                            req_data_byte == SIZE_UNKNOWN_CODE) begin
                  // one-byte unknown-size code
                  emit            = 1'b1;
                  clear           = 1'b1;
                  rsp_id_in       = id_acc_ff;
                  rsp_id_len_in   = id_cnt_ff;
                  rsp_size_in     = {48'd0, SIZE_UNKNOWN_CODE};
                  rsp_size_len_in = size_len;
                  rsp_unknown_in  = 1'b1;
               end else begin
                  if (remain_ff == 4'd0) begin
                     size_acc_in = {48'd0, req_data_byte & ~lead_mask};
                     size_cnt_in = size_len;
                     rem_next    = size_len - 4'd1;
                  end else begin
                     size_acc_in = {size_acc_ff[47:0], req_data_byte};
                     rem_next    = remain_ff - 4'd1;
                  end
                  remain_in = rem_next;
                  if (rem_next == 4'd0) begin
                     emit            = 1'b1;
                     clear           = 1'b1;
                     rsp_id_in       = id_acc_ff;
                     rsp_id_len_in   = id_cnt_ff;
                     rsp_size_in     = size_acc_in;
                     rsp_size_len_in = size_cnt_in;
                  end else if (req_end_of_data) begin
                     emit       = 1'b1;
                     clear      = 1'b1;
                     rsp_err_in = ERR_TRUNC;
                  end
               end
            end
            default: begin
               clear = 1'b1;
            end
         endcase
      end

      if (clear) begin
         phase_in    = PHASE_ID;
         remain_in   = 4'd0;
         id_acc_in   = '0;
         id_cnt_in   = '0;
         size_acc_in = '0;
         size_cnt_in = '0;
      end

      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   // Parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_ID;
         remain_ff   <= '0;
         id_acc_ff   <= '0;
         id_cnt_ff   <= '0;
         size_acc_ff <= '0;
         size_cnt_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         remain_ff   <= remain_in;
         id_acc_ff   <= id_acc_in;
         id_cnt_ff   <= id_cnt_in;
         size_acc_ff <= size_acc_in;
         size_cnt_ff <= size_cnt_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_id_ff       <= rsp_id_in;
         rsp_id_len_ff   <= rsp_id_len_in;
         rsp_size_ff     <= rsp_size_in;
         rsp_size_len_ff <= rsp_size_len_in;
         rsp_unknown_ff  <= rsp_unknown_in;
         rsp_err_ff      <= rsp_err_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_element_id   = rsp_id_ff;
   assign rsp_id_length    = rsp_id_len_ff;
   assign rsp_element_size = rsp_size_ff;
   assign rsp_size_length  = rsp_size_len_ff;
   assign rsp_size_unknown = rsp_unknown_ff;
   assign rsp_error_code   = rsp_err_ff;

   // Checks
   `ASSERT_IMPL(a_err_clears_fields, clock, reset,
      rsp_valid_ff && rsp_err_ff != ERR_NONE,
      rsp_id_len_ff == 3'd0 && rsp_size_len_ff == 4'd0 && rsp_id_ff == 32'd0,
      "error result carries nonzero fields")
   `ASSERT_IMPL(a_ok_has_lengths, clock, reset,
      rsp_valid_ff && rsp_err_ff == ERR_NONE,
      rsp_id_len_ff != 3'd0 && rsp_size_len_ff != 4'd0,
      "good result without ID or size length")
   `ASSERT_IMPL(a_unknown_form, clock, reset,
      rsp_valid_ff && rsp_unknown_ff,
      rsp_size_len_ff == 4'd1 && rsp_size_ff == {48'd0, SIZE_UNKNOWN_CODE},
      "unknown size flag with wrong size field")
   `ASSERT_IMPL(a_size_phase_has_id, clock, reset,
      phase_ff == PHASE_SIZE,
      id_cnt_ff != 3'd0 && remain_ff == 4'd0 || id_cnt_ff != 3'd0 && size_cnt_ff != 4'd0,
      "size phase entered without an ID")

endmodule

@@ tb/ebml_header_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels, decodes the accepted byte stream on its own and
// compares every returned header word against the oldest predicted one.
module ebml_header_checker
   import ebml_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_element_id,
   input  logic [2:0]  rsp_id_length,
   input  logic [55:0] rsp_element_size,
   input  logic [3:0]  rsp_size_length,
   input  logic        rsp_size_unknown,
   input  logic [1:0]  rsp_error_code,
   output int          fail_count,
   output int          pending_count,
   output int          result_count,
   output int          error_result_count,
   output int          unknown_size_count
);

   typedef struct packed {
      logic [31:0]    element_id;
      logic [2:0]     id_length;
      logic [55:0]    element_size;
      logic [3:0]     size_length;
      logic           size_unknown;
      error_code_type error_code;
   } header_result_type;

   // Decoder state, mirrors what the parser must hold between bytes
   phase_type   hdr_phase;
   logic [3:0]  bytes_left;
   logic [31:0] id_shift;
   logic [2:0]  id_count;
   logic [55:0] size_shift;
   logic [3:0]  size_count;

   header_result_type header_q[$];

   function automatic void restart_parse();
      hdr_phase  = PHASE_ID;
      bytes_left = 4'd0;
      id_shift   = 32'd0;
      id_count   = 3'd0;
      size_shift = 56'd0;
      size_count = 4'd0;
   endfunction

   // ID length: first marker among the top nibble
   function automatic int unsigned id_marker_length(input logic [7:0] b);
      casez (b[7:4])
         4'b1???: return 1;
         4'b01??: return 2;
         4'b001?: return 3;
         4'b0001: return 4;
         default: return 0;
      endcase
   endfunction

   // Size length: position of the highest set bit, 0 for a zero byte
   function automatic int unsigned size_marker_length(input logic [7:0] b);
      int unsigned len;
      len = 0;
      for (int i = 7; i >= 0; i--) begin
         if (b[i] && len == 0) len = 8 - i;
      end
      return len;
   endfunction

   function automatic header_result_type finished_header(input logic unknown);
      header_result_type res;
      res.element_id   = id_shift;
      res.id_length    = id_count;
      res.element_size = size_shift;
      res.size_length  = size_count;
      res.size_unknown = unknown;
      res.error_code   = ERR_NONE;
      restart_parse();
      return res;
   endfunction

   // Advance the decoder by one byte; returns 1 when a header word is due
   function automatic bit decode_byte(input logic [7:0] b, input logic eod,
                                      output header_result_type res);
      int unsigned len;
      res = '0;
      if (hdr_phase == PHASE_ID) begin
         if (bytes_left == 0) begin
            len = id_marker_length(b);
            if (len == 0 || len > MAX_ID_BYTES) begin
               res.error_code = ERR_ID_LEAD;
               restart_parse();
               return 1'b1;
            end
            id_shift   = {24'd0, b};
            id_count   = 3'd1;
            bytes_left = 4'(len - 1);
         end else begin
            id_shift   = {id_shift[23:0], b};
            id_count   = id_count + 3'd1;
            bytes_left = bytes_left - 4'd1;
         end
         if (bytes_left == 0) hdr_phase = PHASE_SIZE;
         if (eod) begin
            res.error_code = ERR_TRUNC;
            restart_parse();
            return 1'b1;
         end
         return 1'b0;
      end

      // size field
      if (bytes_left == 0) begin
         len = size_marker_length(b);
         if (len == 0 || len > MAX_SIZE_BYTES) begin
            res.error_code = ERR_SIZE_LEAD;
            restart_parse();
            return 1'b1;
         end
         size_count = 4'(len);
         if (len == 1 && b == SIZE_UNKNOWN_CODE) begin
            size_shift = {48'd0, SIZE_UNKNOWN_CODE};
            res = finished_header(1'b1);
            return 1'b1;
         end
         size_shift = {48'd0, b & ~(8'h80 >> (len - 1))};
         bytes_left = 4'(len - 1);
      end else begin
         size_shift = {size_shift[47:0], b};
         bytes_left = bytes_left - 4'd1;
      end
      if (bytes_left == 0) begin
         res = finished_header(1'b0);
         return 1'b1;
      end
      if (eod) begin
         res.error_code = ERR_TRUNC;
         restart_parse();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want_v,
                                       input logic [63:0] got_v);
      if (got_v !== want_v) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
         fail_count++;
      end
   endfunction

   // Sample both channels at the rising edge
   always @(posedge clock) begin : watch
      header_result_type predicted;
      header_result_type oldest;
      if (reset) begin
         restart_parse();
         header_q.delete();
         fail_count         = 0;
         result_count       = 0;
         error_result_count = 0;
         unknown_size_count = 0;
      end else begin
         if (req_valid && req_ready) begin
            if (decode_byte(req_data_byte, req_end_of_data, predicted))
               header_q.push_back(predicted);
         end
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (rsp_error_code != ERR_NONE) error_result_count++;
            if (rsp_size_unknown) unknown_size_count++;
            if (header_q.size() == 0) begin
               $error("header word with no byte stream behind it: id 0x%0h, error %0d",
                      rsp_element_id, rsp_error_code);
               fail_count++;
            end else begin
               oldest = header_q.pop_front();
               check_field("element_id", oldest.element_id, rsp_element_id);
               check_field("id_length", oldest.id_length, rsp_id_length);
               check_field("element_size", oldest.element_size, rsp_element_size);
               check_field("size_length", oldest.size_length, rsp_size_length);
               check_field("size_unknown", oldest.size_unknown, rsp_size_unknown);
               check_field("error_code", oldest.error_code, rsp_error_code);
            end
         end
      end
      pending_count = header_q.size();
   end

endmodule

@@ tb/tb_ebml_element_header_parser_unit.sv @@
`timescale 1ns / 1ps

module tb_ebml_element_header_parser_unit;
   import ebml_pkg::*;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_end_of_data;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_element_id;
   logic [2:0]  rsp_id_length;
   logic [55:0] rsp_element_size;
   logic [3:0]  rsp_size_length;
   logic        rsp_size_unknown;
   logic [1:0]  rsp_error_code;

   int fail_count;
   int pending_count;
   int result_count;
   int error_result_count;
   int unknown_size_count;

   // Traffic shaping knobs, percent of cycles
   int send_idle_pct = 0;
   int stall_pct = 0;
   bit hold_start = 1'b0;
   int hold_left = 0;
   int bytes_sent = 0;

   ebml_element_header_parser_unit u_dut (.*);

   ebml_header_checker u_checker (.*);

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Watchdog
   initial begin
      #(2_000_000);
      $display("Test completed with failures");
      $finish;
   end

   // Result side: random stalls, or a long hold-off when asked for
   always @(negedge clock) begin
      if (hold_start) begin
         hold_start = 1'b0;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Call at a falling edge; returns at the falling edge after acceptance
   task automatic send_byte(input logic [7:0] b, input logic eod);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_data_byte   <= b;
      req_end_of_data <= eod;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Lead byte with its length marker and random bits below it
   function automatic logic [7:0] marked_lead(input int len);
      logic [7:0] r;
      r = 8'($urandom);
      return (r & (8'hFF >> len)) | (8'h80 >> (len - 1));
   endfunction

   // Well-formed header, optionally cut short by end of data
   task automatic send_header(input int id_len, input int size_len, input bit unknown_size,
                              input bit eod_last, input bit truncate);
      logic [7:0] hdr[$];
      int stop;
      hdr.push_back(marked_lead(id_len));
      repeat (id_len - 1) hdr.push_back(8'($urandom));
      if (unknown_size) begin
         hdr.push_back(SIZE_UNKNOWN_CODE);
      end else begin
         hdr.push_back(marked_lead(size_len));
         repeat (size_len - 1) hdr.push_back(8'($urandom));
      end
      stop = hdr.size() - 1;
      if (truncate) stop = $urandom_range(hdr.size() - 2);
      for (int i = 0; i <= stop; i++)
         send_byte(hdr[i], (i == stop) && (truncate || eod_last));
   endtask

   // Bad ID lead byte, or a good ID followed by a zero size lead
   task automatic send_broken();
      int id_len;
      id_len = $urandom_range(1, 4);
      if ($urandom_range(1) == 1) begin
         send_byte(8'($urandom_range(15)), $urandom_range(7) == 0);
      end else begin
         send_byte(marked_lead(id_len), 1'b0);
         repeat (id_len - 1) send_byte(8'($urandom), 1'b0);
         send_byte(8'h00, $urandom_range(7) == 0);
      end
   endtask

   initial begin
      logic [8:0] directed[$];
      int pick;
      int phase_end;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data_byte   = 8'h00;
      req_end_of_data = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: {end_of_data, byte}
      directed = '{
         9'h080, 9'h080,                                   // smallest header
         9'h01F, 9'h0FF, 9'h0FF, 9'h0FF,                   // 4-byte ID, all ones
         9'h001, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF,           // 8-byte size, largest value
         9'h0FF, 9'h0FF, 9'h0FF,
         9'h000,                                           // no ID marker
         9'h10F,                                           // no ID marker on last byte
         9'h0A3, 9'h000,                                   // zero size lead
         9'h042, 9'h086, 9'h0FF,                           // unknown size
         9'h11A,                                           // buffer ends inside ID
         9'h081, 9'h140,                                   // buffer ends inside size
         9'h0EC, 9'h181                                    // header ends with buffer
      };
      foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8]);

      // Random: mostly valid headers, some broken ones and noise
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 49; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 49; end
            default: begin send_idle_pct = 15; stall_pct = 15; end
         endcase
         phase_end = bytes_sent + 400;
         while (bytes_sent < phase_end) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
               send_header($urandom_range(1, 4), $urandom_range(1, 8),
                           $urandom_range(9) == 0, $urandom_range(6) == 0,
                           $urandom_range(9) == 0);
            end else if (pick < 87) begin
               send_broken();
            end else begin
               repeat ($urandom_range(1, 4))
                  send_byte(8'($urandom), $urandom_range(19) == 0);
            end
         end
         // Output held off while headers keep coming, so the input backs up
         if (p == 0) begin
            hold_start = 1'b1;
            repeat (6) send_header($urandom_range(1, 4), $urandom_range(1, 3), 1'b0,
                                   1'b0, 1'b0);
         end
      end
      req_valid <= 1'b0;

      // Drain
      pick = 0;
      while (pending_count != 0 && pick < 5000) begin
         @(negedge clock);
         pick++;
      end
      repeat (8) @(negedge clock);
      if (pending_count != 0)
         $error("%0d predicted header words never arrived", pending_count);

      $display("Parsed %0d stream bytes into %0d header words (%0d errors, %0d unknown sizes).",
               bytes_sent, result_count, error_result_count, unknown_size_count);
      $display("Traffic mixes: no idling, sender 49%%, receiver 49%%, both 15%%, one long hold-off.");
      if (fail_count == 0 && pending_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ ebml_element_header_parser_unit.f @@
+incdir+src
src/ebml_pkg.sv
src/ebml_element_header_parser_unit.sv
tb/ebml_header_checker.sv
tb/tb_ebml_element_header_parser_unit.sv
